@@ rtl/hng_pkg.sv @@
// Shared types, constants and the step table for the heightmap normal generator.
// Used by hng_ctrl, hng_dp and the top level; depends on nothing else.
package hng_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_ROWS      = 4096;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_SPACING_X    = 3'd2;
  localparam logic [2:0] REG_SPACING_Z    = 3'd3;
  localparam logic [2:0] REG_HEIGHT_SCALE = 3'd4;
  localparam logic [2:0] REG_COUNT        = 3'd5;

  localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd256;
  localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd256;
  localparam logic [15:0] RST_SPACING_X    = 16'd256;
  localparam logic [15:0] RST_SPACING_Z    = 16'd256;
  localparam logic [15:0] RST_HEIGHT_SCALE = 16'd1280;

  localparam logic       OP_SAMPLE = 1'b0;
  localparam logic       OP_FLUSH  = 1'b1;

  localparam int READ_LAST = 3;
  localparam int MUL_STEPS = 13;
  localparam int SQ_LAST   = 3;
  localparam int ROOT_TOP  = 30;
  localparam int DIV_LAST  = 17;
  localparam int COMP_LAST = 2;
  localparam logic [15:0] Q_ONE = 16'd16384;

  typedef struct packed {
    logic        opcode;
    logic [15:0] height;
  } in_word_t;

  typedef struct packed {
    logic [27:0]        pos_x;
    logic [15:0]        pos_y;
    logic [27:0]        pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [21:0]        vertex_number;
    logic               frame_last;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_READ, S_WRITE, S_MUL, S_NORM, S_SQ, S_ROOT, S_DIV, S_LOAD
  } ctrl_state_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_LOAD, DP_READ, DP_WRITE,
    DP_YL, DP_YC, DP_YR, DP_YU, DP_YD, DP_DIFF,
    DP_S0, DP_S1, DP_S2, DP_PX, DP_PZ, DP_VN, DP_MAG,
    DP_NORM, DP_SQ, DP_ROOT, DP_DIV_INIT, DP_DIV_STEP, DP_DIV_DONE, DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [4:0] idx;
    logic [1:0] comp;
  } dp_cmd_t;

  typedef struct packed {
    logic drop;
    logic emit;
    logic top_zero;
    logic norm_ok;
    logic out_busy;
  } dp_stat_t;

  // order of the shared-multiplier steps
  function automatic dp_op_t mul_seq(input logic [3:0] step);
    dp_op_t op;
    case (step)
      4'd0:    op = DP_YL;
      4'd1:    op = DP_YC;
      4'd2:    op = DP_YR;
      4'd3:    op = DP_YU;
      4'd4:    op = DP_YD;
      4'd5:    op = DP_DIFF;
      4'd6:    op = DP_S0;
      4'd7:    op = DP_S1;
      4'd8:    op = DP_S2;
      4'd9:    op = DP_PX;
      4'd10:   op = DP_PZ;
      4'd11:   op = DP_VN;
      4'd12:   op = DP_MAG;
      default: op = DP_NOP;
    endcase
    return op;
  endfunction

endpackage

@@ rtl/heightmap_normal_generator.sv @@
// Top level of the heightmap normal generator: APB register file, sequencer
// and datapath. Depends on hng_pkg, hng_ctrl and hng_dp.
//
//  channel   direction  handshake                       word
//  --------  ---------  ------------------------------  --------------------------
//  sample    in         sample_valid / sample_ready     hng_pkg::in_word_t
//  vertex    out        vertex_valid / vertex_ready     hng_pkg::out_word_t
//  apb       in/out     psel, penable, pwrite, pready   paddr, pwdata, prdata
//
//  One word at a time. A vertex is built from 4 row-buffer reads, the
//  shared-multiplier steps, one-bit normalize shifts, a 31-step square
//  root and three 16-step divisions; a dropped word returns to idle from
//  the check state. Reset is synchronous, active high; it restores
//  register defaults and restarts the frame. Row buffers come up undefined.
//  A finished vertex waits in the output register while the next word is read.
module heightmap_normal_generator #(
  parameter int MAX_WIDTH = hng_pkg::MAX_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  hng_pkg::in_word_t  sample,
  output logic               vertex_valid,
  input  logic               vertex_ready,
  output hng_pkg::out_word_t vertex,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import hng_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [10:0] image_width;
  logic [12:0] image_height;
  logic [15:0] spacing_x, spacing_z, height_scale;

  logic        wr_en, restart;
  logic [2:0]  reg_idx;
  logic [31:0] iw_ext, gw_ext;
  logic [WW-1:0] grid_w;
  logic [12:0] grid_h;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  // any write inside the register map restarts the frame
  assign restart = wr_en && (reg_idx < REG_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
      spacing_x    <= RST_SPACING_X;
      spacing_z    <= RST_SPACING_Z;
      height_scale <= RST_HEIGHT_SCALE;
    end else if (wr_en) begin
      case (reg_idx)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[10:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[12:0];
        REG_SPACING_X:    spacing_x    <= pwdata[15:0];
        REG_SPACING_Z:    spacing_z    <= pwdata[15:0];
        REG_HEIGHT_SCALE: height_scale <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      REG_SPACING_X:    prdata = 32'(spacing_x);
      REG_SPACING_Z:    prdata = 32'(spacing_z);
      REG_HEIGHT_SCALE: prdata = 32'(height_scale);
      default:          prdata = '0;
    endcase
  end

  // clamp the grid size to what the buffers and row counter hold
  always_comb begin
    iw_ext = 32'(image_width);
    if (iw_ext == 32'd0) gw_ext = 32'd1;
    else if (iw_ext > 32'(MAX_WIDTH)) gw_ext = 32'(MAX_WIDTH);
    else gw_ext = iw_ext;
    grid_w = WW'(gw_ext);
    if (image_height == 13'd0) grid_h = 13'd1;
    else if (image_height > 13'(MAX_ROWS)) grid_h = 13'(MAX_ROWS);
    else grid_h = image_height;
  end

  hng_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  hng_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .sample       (sample),
    .grid_w       (grid_w),
    .grid_h       (grid_h),
    .spacing_x    (spacing_x),
    .spacing_z    (spacing_z),
    .height_scale (height_scale),
    .restart      (restart),
    .vertex_valid (vertex_valid),
    .vertex_ready (vertex_ready),
    .vertex       (vertex)
  );

`ifndef ASSERT_OFF
  // every contributing cross product has a non-negative y term
  a_normal_y_up: assert property (@(posedge clk) disable iff (rst)
    vertex_valid |-> !vertex.normal_y[15])
    else $error("normal_y negative");

  a_normal_x_range: assert property (@(posedge clk) disable iff (rst)
    vertex_valid |-> ($signed(vertex.normal_x) <= 16384 &&
                      $signed(vertex.normal_x) >= -16384))
    else $error("normal_x out of unit range");

  // one word in flight: the sequencer leaves idle on accept
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("second word accepted while busy");
`endif

endmodule

@@ rtl/hng_ctrl.sv @@
// Sequencer of the heightmap normal generator: steps the datapath per word.
// Depends on hng_pkg.
module hng_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  hng_pkg::dp_stat_t stat,
  output hng_pkg::dp_cmd_t  cmd
);
  import hng_pkg::*;

  ctrl_state_t state, state_next;
  logic [4:0]  cnt, cnt_next;
  logic [1:0]  comp, comp_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      comp  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      comp  <= comp_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    comp_next  = comp;
    case (state)
      S_IDLE: begin
        if (sample_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        cnt_next   = '0;
        state_next = stat.drop ? S_IDLE : S_READ;
      end
      S_READ: begin
        if (cnt == 5'(READ_LAST)) state_next = S_WRITE;
        else cnt_next = cnt + 5'd1;
      end
      S_WRITE: begin
        cnt_next   = '0;
        state_next = stat.emit ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        if (cnt == 5'(MUL_STEPS - 1)) state_next = S_NORM;
        else cnt_next = cnt + 5'd1;
      end
      S_NORM: begin
        cnt_next = '0;
        if (stat.top_zero) state_next = S_LOAD;
        else if (stat.norm_ok) state_next = S_SQ;
      end
      S_SQ: begin
        if (cnt == 5'(SQ_LAST)) begin
          state_next = S_ROOT;
          cnt_next   = 5'(ROOT_TOP);
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      S_ROOT: begin
        if (cnt == '0) begin
          state_next = S_DIV;
          comp_next  = '0;
        end else begin
          cnt_next = cnt - 5'd1;
        end
      end
      S_DIV: begin
        if (cnt == 5'(DIV_LAST)) begin
          cnt_next = '0;
          if (comp == 2'(COMP_LAST)) state_next = S_LOAD;
          else comp_next = comp + 2'd1;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      S_LOAD: begin
        if (!stat.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    sample_ready = 1'b0;
    cmd.op   = DP_NOP;
    cmd.idx  = cnt;
    cmd.comp = comp;
    case (state)
      S_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) cmd.op = DP_LOAD;
      end
      S_CHECK: cmd.op = DP_NOP;
      S_READ:  cmd.op = DP_READ;
      S_WRITE: cmd.op = DP_WRITE;
      S_MUL:   cmd.op = mul_seq(cnt[3:0]);
      S_NORM:  cmd.op = DP_NORM;
      S_SQ:    cmd.op = DP_SQ;
      S_ROOT:  cmd.op = DP_ROOT;
      S_DIV: begin
        if (cnt == '0) cmd.op = DP_DIV_INIT;
        else if (cnt == 5'(DIV_LAST)) cmd.op = DP_DIV_DONE;
        else cmd.op = DP_DIV_STEP;
      end
      S_LOAD:  cmd.op = stat.out_busy ? DP_NOP : DP_OUT;
      default: cmd.op = DP_NOP;
    endcase
  end

endmodule

@@ rtl/hng_dp.sv @@
// Datapath of the heightmap normal generator: row buffers, counters, shared
// multiplier, normalize shifter, square root, divider and output register.
// Depends on hng_pkg.
module hng_dp #(
  parameter int MAX_WIDTH = hng_pkg::MAX_WIDTH_DEF,
  localparam int AW = $clog2(MAX_WIDTH),
  localparam int WW = $clog2(MAX_WIDTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  hng_pkg::dp_cmd_t   cmd,
  output hng_pkg::dp_stat_t  stat,
  input  hng_pkg::in_word_t  sample,
  input  logic [WW-1:0]      grid_w,
  input  logic [12:0]        grid_h,
  input  logic [15:0]        spacing_x,
  input  logic [15:0]        spacing_z,
  input  logic [15:0]        height_scale,
  input  logic               restart,
  output logic               vertex_valid,
  input  logic               vertex_ready,
  output hng_pkg::out_word_t vertex
);
  import hng_pkg::*;

  logic [15:0] newer_mem [MAX_WIDTH];
  logic [15:0] older_mem [MAX_WIDTH];
  logic [15:0] nr_q, or_q;
  logic [AW-1:0] nr_addr;

  logic [AW-1:0] col_cnt, flush_cnt;
  logic [12:0]   row_cnt;
  logic [15:0]   wr0;

  logic          flush_q;
  logic [15:0]   hv_q;
  logic [AW-1:0] c_q;
  logic [12:0]   row_q;
  logic          has_l, has_r, has_u, has_d, last_q, drop_q, emit_q;

  logic [15:0] hl, hc, hr, hu, hd;
  logic [15:0] yl, yc, yr, yu, yd;
  logic signed [19:0] da, db;
  logic signed [35:0] s0, s1, s2;
  logic [27:0] pos_x, pos_z;
  logic [21:0] vn;

  logic [34:0] m [3];
  logic        sg [3];
  logic [15:0] nq [3];
  logic [34:0] top;
  logic [59:0] p;
  logic [61:0] acc, v;
  logic [62:0] r;
  logic [30:0] len, rem;
  logic [15:0] nlow, quo;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;

  // load-time decode
  logic [AW-1:0] cnt_sel, ld_c;
  logic [WW-1:0] ld_c1, c1;
  logic          ld_drop, ld_emit, ld_hu, ld_hd, ld_last;
  logic [12:0]   ld_row;

  logic [1:0]  cnt_lr, cnt_ud, cnt_l, cnt_r, cnt_u, cnt_d;
  logic [17:0] sxc;
  logic signed [19:0] dl, dr, du, dd;
  logic [62:0] rb, rt;
  logic [44:0] nfull;
  logic [31:0] rem2;
  logic [15:0] qc;

  function automatic logic signed [19:0] times_cnt(input logic signed [19:0] d,
                                                   input logic [1:0] k);
    logic signed [19:0] res;
    case (k)
      2'd1:    res = d;
      2'd2:    res = d <<< 1;
      default: res = '0;
    endcase
    return res;
  endfunction

  always_comb begin
    cnt_sel = sample.opcode ? flush_cnt : col_cnt;
    ld_c    = (WW'(cnt_sel) >= grid_w) ? AW'(grid_w - WW'(1)) : cnt_sel;
    ld_c1   = WW'(ld_c) + WW'(1);
    if (sample.opcode == OP_FLUSH) begin
      ld_drop = row_cnt < grid_h;
      ld_emit = 1'b1;
      ld_row  = grid_h - 13'd1;
      ld_hu   = 1'b0;
      ld_hd   = grid_h >= 13'd2;
      ld_last = ld_c1 == grid_w;
    end else begin
      ld_drop = row_cnt >= grid_h;
      ld_emit = row_cnt != 13'd0;
      ld_row  = row_cnt - 13'd1;
      ld_hu   = 1'b1;
      ld_hd   = row_cnt >= 13'd2;
      ld_last = 1'b0;
    end
    c1 = WW'(c_q) + WW'(1);
  end

  always_comb begin
    cnt_lr = 2'(has_l) + 2'(has_r);
    cnt_ud = 2'(has_u) + 2'(has_d);
    cnt_l  = has_l ? cnt_ud : 2'd0;
    cnt_r  = has_r ? cnt_ud : 2'd0;
    cnt_u  = has_u ? cnt_lr : 2'd0;
    cnt_d  = has_d ? cnt_lr : 2'd0;
    if (cnt_lr == 2'd0 || cnt_ud == 2'd0) sxc = '0;
    else if (cnt_lr == 2'd2 && cnt_ud == 2'd2) sxc = {spacing_x, 2'b00};
    else if (cnt_lr == 2'd2 || cnt_ud == 2'd2) sxc = {1'b0, spacing_x, 1'b0};
    else sxc = {2'b00, spacing_x};
    dl = $signed({4'b0, yl}) - $signed({4'b0, yc});
    dr = $signed({4'b0, yr}) - $signed({4'b0, yc});
    du = $signed({4'b0, yu}) - $signed({4'b0, yc});
    dd = $signed({4'b0, yd}) - $signed({4'b0, yc});
  end

  always_comb begin
    top = m[0];
    if (m[1] > top) top = m[1];
    if (m[2] > top) top = m[2];
    stat.drop     = drop_q;
    stat.emit     = emit_q;
    stat.top_zero = top == '0;
    stat.norm_ok  = top[34:29] == 6'b000001;
    stat.out_busy = vertex_valid && !vertex_ready;
  end

  // shared multiplier, operands picked by step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      DP_YL: begin mul_a = 32'(hl); mul_b = 32'(height_scale); end
      DP_YC: begin mul_a = 32'(hc); mul_b = 32'(height_scale); end
      DP_YR: begin mul_a = 32'(hr); mul_b = 32'(height_scale); end
      DP_YU: begin mul_a = 32'(hu); mul_b = 32'(height_scale); end
      DP_YD: begin mul_a = 32'(hd); mul_b = 32'(height_scale); end
      DP_S0: begin mul_a = 32'(da); mul_b = 32'(spacing_z); end
      DP_S1: begin mul_a = 32'(sxc); mul_b = 32'(spacing_z); end
      DP_S2: begin mul_a = 32'(spacing_x); mul_b = 32'(db); end
      DP_PX: begin mul_a = 32'(c_q); mul_b = 32'(spacing_x); end
      DP_PZ: begin mul_a = 32'(row_q); mul_b = 32'(spacing_z); end
      DP_VN: begin mul_a = 32'(row_q); mul_b = 32'(grid_w); end
      DP_SQ: begin
        case (cmd.idx[1:0])
          2'd0:    begin mul_a = 32'(m[0][29:0]); mul_b = 32'(m[0][29:0]); end
          2'd1:    begin mul_a = 32'(m[1][29:0]); mul_b = 32'(m[1][29:0]); end
          2'd2:    begin mul_a = 32'(m[2][29:0]); mul_b = 32'(m[2][29:0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    prod = mul_a * mul_b;
  end

  always_comb begin
    case (cmd.idx[1:0])
      2'd0:    nr_addr = c_q;
      2'd1:    nr_addr = c1[AW-1:0];
      2'd2:    nr_addr = c_q - AW'(1);
      default: nr_addr = c_q;
    endcase
    rb    = 63'(1) << {cmd.idx, 1'b0};
    rt    = r + rb;
    nfull = 45'({m[cmd.comp][29:0], 14'b0}) + 45'(len[30:1]);
    rem2  = {rem, nlow[15]};
    qc    = (quo > Q_ONE) ? Q_ONE : quo;
    len   = r[30:0];
  end

  // row buffers: registered read, one write port each
  always_ff @(posedge clk) begin
    if (cmd.op == DP_WRITE && !flush_q) begin
      newer_mem[c_q] <= hv_q;
      older_mem[c_q] <= hc;
    end
    nr_q <= newer_mem[nr_addr];
    or_q <= older_mem[c_q];
  end

  // frame counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt      <= '0;
      row_cnt      <= '0;
      flush_cnt    <= '0;
      wr0          <= '0;
      vertex_valid <= 1'b0;
      drop_q       <= 1'b0;
      emit_q       <= 1'b0;
    end else begin
      if (restart) begin
        col_cnt   <= '0;
        row_cnt   <= '0;
        flush_cnt <= '0;
      end else if (cmd.op == DP_WRITE) begin
        if (flush_q) begin
          if (c1 >= grid_w) begin
            col_cnt   <= '0;
            row_cnt   <= '0;
            flush_cnt <= '0;
          end else begin
            flush_cnt <= c1[AW-1:0];
          end
        end else begin
          wr0 <= hc;
          if (c1 >= grid_w) begin
            col_cnt <= '0;
            row_cnt <= row_cnt + 13'd1;
          end else begin
            col_cnt <= c1[AW-1:0];
          end
        end
      end
      if (cmd.op == DP_LOAD) begin
        drop_q <= ld_drop;
        emit_q <= ld_emit;
      end
      if (cmd.op == DP_OUT) vertex_valid <= 1'b1;
      else if (vertex_ready) vertex_valid <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        flush_q <= sample.opcode;
        hv_q    <= sample.height;
        c_q     <= ld_c;
        row_q   <= ld_row;
        has_l   <= ld_c != '0;
        has_r   <= ld_c1 < grid_w;
        has_u   <= ld_hu;
        has_d   <= ld_hd;
        last_q  <= ld_last;
      end
      DP_READ: begin
        case (cmd.idx[1:0])
          2'd1: begin
            hc <= nr_q;
            hd <= or_q;
          end
          2'd2: hr <= nr_q;
          2'd3: begin
            hl <= flush_q ? nr_q : wr0;
            hu <= flush_q ? 16'd0 : hv_q;
          end
          default: ;
        endcase
      end
      DP_YL:   yl <= prod[31:16];
      DP_YC:   yc <= prod[31:16];
      DP_YR:   yr <= prod[31:16];
      DP_YU:   yu <= prod[31:16];
      DP_YD:   yd <= prod[31:16];
      DP_DIFF: begin
        da <= times_cnt(dl, cnt_l) - times_cnt(dr, cnt_r);
        db <= times_cnt(dd, cnt_d) - times_cnt(du, cnt_u);
      end
      DP_S0:   s0 <= prod[35:0];
      DP_S1:   s1 <= prod[35:0];
      DP_S2:   s2 <= prod[35:0];
      DP_PX:   pos_x <= prod[27:0];
      DP_PZ:   pos_z <= prod[27:0];
      DP_VN:   vn <= prod[21:0] + 22'(c_q);
      DP_MAG: begin
        m[0]  <= 35'(s0[35] ? -s0 : s0);
        m[1]  <= 35'(s1[35] ? -s1 : s1);
        m[2]  <= 35'(s2[35] ? -s2 : s2);
        sg[0] <= s0[35];
        sg[1] <= s1[35];
        sg[2] <= s2[35];
        nq[0] <= '0;
        nq[1] <= '0;
        nq[2] <= '0;
      end
      DP_NORM: begin
        // one bit per cycle toward [2^29, 2^30); right shifts truncate
        if (top[34:30] != '0) begin
          m[0] <= m[0] >> 1;
          m[1] <= m[1] >> 1;
          m[2] <= m[2] >> 1;
        end else if (top != '0 && !top[29]) begin
          m[0] <= m[0] << 1;
          m[1] <= m[1] << 1;
          m[2] <= m[2] << 1;
        end
      end
      DP_SQ: begin
        case (cmd.idx[1:0])
          2'd0: p <= prod[59:0];
          2'd1: begin
            acc <= 62'(p);
            p   <= prod[59:0];
          end
          2'd2: begin
            acc <= acc + 62'(p);
            p   <= prod[59:0];
          end
          default: begin
            v <= acc + 62'(p);
            r <= '0;
          end
        endcase
      end
      DP_ROOT: begin
        if ({1'b0, v} >= rt) begin
          v <= v - rt[61:0];
          r <= (r >> 1) + rb;
        end else begin
          r <= r >> 1;
        end
      end
      DP_DIV_INIT: begin
        rem  <= 31'(nfull[44:16]);
        nlow <= nfull[15:0];
        quo  <= '0;
      end
      DP_DIV_STEP: begin
        if (rem2 >= {1'b0, len}) begin
          rem <= 31'(rem2 - {1'b0, len});
          quo <= {quo[14:0], 1'b1};
        end else begin
          rem <= rem2[30:0];
          quo <= {quo[14:0], 1'b0};
        end
        nlow <= {nlow[14:0], 1'b0};
      end
      DP_DIV_DONE: nq[cmd.comp] <= sg[cmd.comp] ? -qc : qc;
      DP_OUT: begin
        vertex.pos_x         <= pos_x;
        vertex.pos_y         <= yc;
        vertex.pos_z         <= pos_z;
        vertex.normal_x      <= nq[0];
        vertex.normal_y      <= nq[1];
        vertex.normal_z      <= nq[2];
        vertex.vertex_number <= vn;
        vertex.frame_last    <= last_q;
      end
      default: ;
    endcase
  end

endmodule

@@ tb/sv/heightmap_normal_generator_tb.sv @@
// Self-checking bench for heightmap_normal_generator: drives height and flush words,
// predicts every vertex in-bench and compares it field by field. Depends on hng_pkg.
module heightmap_normal_generator_tb;
  import hng_pkg::*;

  localparam int STALL_LIMIT = 50000;   // cycles with no handshake before giving up
  localparam int DRAIN_WAIT  = 200;     // longer than the slowest vertex
  localparam int LONG_HOLD   = 3000;    // receiver back-pressure stretch
  localparam int ITEM_GOAL   = 1800;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        sample_valid = 1'b0;
  logic        sample_ready;
  in_word_t    sample = '0;
  logic        vertex_valid;
  logic        vertex_ready = 1'b0;
  out_word_t   vertex;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  heightmap_normal_generator u_dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
    .vertex_valid(vertex_valid), .vertex_ready(vertex_ready), .vertex(vertex),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Words waiting to be offered, vertices waiting to come out.
  in_word_t  height_words[$];
  out_word_t vertex_q[$];
  int        item_count = 0;
  int        mismatches = 0;
  int        stall_cycles = 0;
  int        cyc = 0;
  bit        word_taken = 0;
  int        hold_left = 0;
  bit        hold_done = 0;

  // Shadow registers and frame state of the vertex predictor.
  logic [10:0] cfg_w     = RST_IMAGE_WIDTH;
  logic [12:0] cfg_h     = RST_IMAGE_HEIGHT;
  logic [15:0] cfg_sx    = RST_SPACING_X;
  logic [15:0] cfg_sz    = RST_SPACING_Z;
  logic [15:0] cfg_scale = RST_HEIGHT_SCALE;
  logic [15:0] prev_row[MAX_WIDTH_DEF];
  logic [15:0] cur_row[MAX_WIDTH_DEF];
  logic [15:0] win[4];
  int unsigned col_n = 0, row_n = 0, flush_n = 0;

  // Random idling, switched off over a quiet window so back-to-back traffic is seen too.
  function automatic bit idle_now();
    if (cyc >= 30000 && cyc < 60000) return 1'b0;
    return $urandom_range(99) < 7;
  endfunction

  function automatic int unsigned grid_w();
    if (cfg_w == 0) return 1;
    if (cfg_w > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return cfg_w;
  endfunction

  function automatic int unsigned grid_h();
    if (cfg_h == 0) return 1;
    if (cfg_h > MAX_ROWS) return MAX_ROWS;
    return cfg_h;
  endfunction

  function automatic longint scaled_y(logic [15:0] h);
    longint unsigned p;
    p = 64'(h) * 64'(cfg_scale);
    return longint'(p >> 16);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Sum the neighbour cross products, normalize to Q1.14 and queue the vertex.
  task automatic predict_vertex(int unsigned r, int unsigned c, logic [15:0] hl,
                                logic [15:0] hc, logic [15:0] hr, logic [15:0] hu,
                                logic [15:0] hd, bit has_l, bit has_r, bit has_u,
                                bit has_d, bit last);
    longint sx, sz, yc, dl, dr, du, dd;
    longint s[3];
    longint unsigned m[3], top, len, q;
    logic [15:0] n[3];
    out_word_t v;
    sx = cfg_sx;
    sz = cfg_sz;
    yc = scaled_y(hc);
    dl = scaled_y(hl) - yc;
    dr = scaled_y(hr) - yc;
    du = scaled_y(hu) - yc;
    dd = scaled_y(hd) - yc;
    s = '{0, 0, 0};
    if (has_u && has_l) begin s[0] += dl * sz; s[1] += sx * sz; s[2] -= sx * du; end
    if (has_u && has_r) begin s[0] -= sz * dr; s[1] += sx * sz; s[2] -= sx * du; end
    if (has_d && has_l) begin s[0] += sz * dl; s[1] += sx * sz; s[2] += sx * dd; end
    if (has_d && has_r) begin s[0] -= sz * dr; s[1] += sx * sz; s[2] += sx * dd; end
    for (int i = 0; i < 3; i++) m[i] = (s[i] < 0) ? longint'(-s[i]) : s[i];
    top = m[0];
    if (m[1] > top) top = m[1];
    if (m[2] > top) top = m[2];
    if (top == 0) begin
      n = '{16'd0, 16'd0, 16'd0};
    end else begin
      while (top >= (64'd1 << 30)) begin
        top = top >> 1;
        for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      end
      while (top < (64'd1 << 29)) begin
        top = top << 1;
        for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      end
      len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
      for (int i = 0; i < 3; i++) begin
        q = (m[i] * 16384 + len / 2) / len;
        if (q > 16384) q = 16384;
        n[i] = (s[i] < 0) ? 16'(-q) : 16'(q);
      end
    end
    v.pos_x         = 28'(64'(c) * cfg_sx);
    v.pos_y         = 16'(yc);
    v.pos_z         = 28'(64'(r) * cfg_sz);
    v.normal_x      = n[0];
    v.normal_y      = n[1];
    v.normal_z      = n[2];
    v.vertex_number = 22'(64'(r) * grid_w() + c);
    v.frame_last    = last;
    vertex_q.push_back(v);
  endtask

  // Advance the frame by one accepted word.
  task automatic step_frame(in_word_t wd);
    int unsigned w, h, c, r;
    logic [15:0] right;
    w = grid_w();
    h = grid_h();
    if (wd.opcode == OP_SAMPLE) begin
      if (row_n >= h) return;               // last row in: drop until flushed
      c = (col_n >= w) ? w - 1 : col_n;
      r = row_n;
      win[1] = cur_row[c];
      win[2] = wd.height;
      win[3] = prev_row[c];
      if (r >= 1) begin
        right = (c + 1 < w) ? cur_row[c + 1] : 16'd0;
        predict_vertex(r - 1, c, win[0], win[1], right, win[2], win[3],
                       c != 0, c + 1 < w, 1'b1, r >= 2, 1'b0);
      end
      win[0] = win[1];
      prev_row[c] = cur_row[c];
      cur_row[c] = wd.height;
      col_n = c + 1;
      if (col_n >= w) begin
        col_n = 0;
        row_n = r + 1;
      end
    end else begin
      if (row_n < h) return;                // flush too early: dropped
      c = (flush_n >= w) ? w - 1 : flush_n;
      win[0] = (c != 0) ? cur_row[c - 1] : 16'd0;
      win[1] = cur_row[c];
      win[2] = 16'd0;
      win[3] = prev_row[c];
      right = (c + 1 < w) ? cur_row[c + 1] : 16'd0;
      predict_vertex(h - 1, c, win[0], win[1], right, 16'd0, win[3],
                     c != 0, c + 1 < w, 1'b0, h >= 2, c + 1 == w);
      flush_n = c + 1;
      if (flush_n >= w) begin
        col_n = 0; row_n = 0; flush_n = 0;
      end
    end
  endtask

  task automatic report(string what, longint got, longint want);
    $display("[%0d] mismatch on %s: got %0d, want %0d", cyc, what, got, want);
    mismatches++;
  endtask

  task automatic check_vertex(out_word_t got, out_word_t want);
    if (got.pos_x != want.pos_x) report("pos_x", got.pos_x, want.pos_x);
    if (got.pos_y != want.pos_y) report("pos_y", got.pos_y, want.pos_y);
    if (got.pos_z != want.pos_z) report("pos_z", got.pos_z, want.pos_z);
    if (got.normal_x !== want.normal_x) report("normal_x", got.normal_x, want.normal_x);
    if (got.normal_y !== want.normal_y) report("normal_y", got.normal_y, want.normal_y);
    if (got.normal_z !== want.normal_z) report("normal_z", got.normal_z, want.normal_z);
    if (got.vertex_number != want.vertex_number)
      report("vertex_number", got.vertex_number, want.vertex_number);
    if (got.frame_last !== want.frame_last)
      report("frame_last", got.frame_last, want.frame_last);
  endtask

  // Sample side: predict on acceptance, check vertices, track progress.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst) begin
      if (sample_valid && sample_ready) begin
        step_frame(sample);
        word_taken = 1'b1;
      end
      if (vertex_valid && vertex_ready) begin
        if (vertex_q.size() == 0) begin
          report("unexpected vertex number", vertex.vertex_number, -1);
        end else begin
          check_vertex(vertex, vertex_q.pop_front());
        end
      end
      if ((sample_valid && sample_ready) || (vertex_valid && vertex_ready) ||
          (psel && penable)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Driver: hold the word until taken, then offer the next one or idle.
  always @(negedge clk) begin
    if (!rst && (!sample_valid || word_taken)) begin
      word_taken = 1'b0;
      if (height_words.size() != 0 && !idle_now()) begin
        sample_valid <= 1'b1;
        sample       <= height_words.pop_front();
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off once a backlog has built up
  // so the block fills and drops sample_ready.
  always @(negedge clk) begin
    if (rst) begin
      vertex_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      vertex_ready <= 1'b0;
    end else if (!hold_done && cyc > 3000 && height_words.size() > 20) begin
      hold_done    <= 1'b1;
      hold_left    <= LONG_HOLD;
      vertex_ready <= 1'b0;
    end else begin
      vertex_ready <= !idle_now();
    end
  end

  // Give up if nothing moves for too long.
  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Register write in a setup and an access phase; every write restarts the frame.
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:  cfg_w     = val[10:0];
      REG_IMAGE_HEIGHT: cfg_h     = val[12:0];
      REG_SPACING_X:    cfg_sx    = val[15:0];
      REG_SPACING_Z:    cfg_sz    = val[15:0];
      REG_HEIGHT_SCALE: cfg_scale = val[15:0];
      default: ;
    endcase
    col_n = 0; row_n = 0; flush_n = 0;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait for every word and vertex to pass, then for a dropped word still in flight.
  task automatic drain();
    while (height_words.size() != 0 || sample_valid || vertex_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic configure(int w, int h, int sx, int sz, int scale);
    drain();
    reg_write(REG_IMAGE_WIDTH, w);
    reg_write(REG_IMAGE_HEIGHT, h);
    reg_write(REG_SPACING_X, sx);
    reg_write(REG_SPACING_Z, sz);
    reg_write(REG_HEIGHT_SCALE, scale);
  endtask

  task automatic push_word(logic op, logic [15:0] h);
    in_word_t wd;
    wd.opcode = op;
    wd.height = h;
    height_words.push_back(wd);
    item_count++;
  endtask

  function automatic logic [15:0] pick_height();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int pick_q88(bit allow_zero);
    case ($urandom_range(5))
      0:       return allow_zero ? 0 : 1;
      1:       return 65535;
      2:       return $urandom_range(128, 1024);
      default: return $urandom_range(allow_zero ? 0 : 1, 65535);
    endcase
  endfunction

  // One whole frame: rows of samples then a flush per column. With noise, mix in
  // early flushes and late samples, both of which the block drops.
  task automatic push_frame(int w, int h, bit noise);
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        if (noise && $urandom_range(19) == 0) push_word(OP_FLUSH, 16'($urandom));
        push_word(OP_SAMPLE, pick_height());
      end
    end
    if (noise && $urandom_range(3) == 0) push_word(OP_SAMPLE, 16'($urandom));
    for (int c = 0; c < w; c++) push_word(OP_FLUSH, 16'($urandom));
  endtask

  initial begin
    int w, h;
    for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
      prev_row[i] = '0;
      cur_row[i]  = '0;
    end
    win = '{16'd0, 16'd0, 16'd0, 16'd0};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset defaults: row-0 samples emit nothing, early flushes are dropped.
    push_word(OP_SAMPLE, 16'h0000);
    push_word(OP_FLUSH, 16'h1234);
    push_word(OP_SAMPLE, 16'hFFFF);
    push_word(OP_SAMPLE, 16'h8001);

    // Single-point grid: no neighbours, so a zero normal.
    configure(1, 1, 256, 256, 1280);
    push_word(OP_SAMPLE, 16'hFFFF);
    push_word(OP_SAMPLE, 16'h5555);   // after the last row: dropped
    push_word(OP_FLUSH, 16'h0000);

    // Extreme spacing and scale on a 3x3 grid of extreme heights.
    configure(3, 3, 65535, 1, 65535);
    for (int i = 0; i < 9; i++) push_word(OP_SAMPLE, (i % 2) ? 16'hFFFF : 16'h0000);
    for (int i = 0; i < 3; i++) push_word(OP_FLUSH, 16'h0);

    // Flat terrain with zero scale, then a frame cut short by a register write.
    configure(2, 1, 1, 65535, 0);
    push_word(OP_SAMPLE, 16'hFFFF);
    push_word(OP_SAMPLE, 16'h0001);
    push_word(OP_FLUSH, 16'h0);
    push_word(OP_FLUSH, 16'h0);
    configure(3, 3, 300, 700, 4000);
    for (int i = 0; i < 4; i++) push_word(OP_SAMPLE, pick_height());

    // Out-of-range sizes: zero width clamps to one, a huge height to the row limit.
    configure(0, 8191, 1000, 2000, 30000);
    for (int i = 0; i < 30; i++) push_word(OP_SAMPLE, pick_height());

    // Widest row (width clamps down from its top value) with a height of zero.
    configure(2047, 0, pick_q88(0), pick_q88(0), pick_q88(1));
    push_frame(MAX_WIDTH_DEF, 1, 1'b0);

    // Random grids, mostly small; now and then leave a frame unfinished.
    while (item_count < ITEM_GOAL + 2100) begin
      w = ($urandom_range(5) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      configure(w, h, pick_q88(0), pick_q88(0), pick_q88(1));
      repeat ($urandom_range(1, 3)) push_frame(w, h, $urandom_range(3) != 0);
      if ($urandom_range(5) == 0)
        for (int i = 0; i < w + 1; i++) push_word(OP_SAMPLE, pick_height());
    end

    drain();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
